// ===== src/qse_pkg.sv =====
package qse_pkg;

  localparam int DATA_WIDTH   = 32;
  localparam int MAX_ELEMENTS = 64;
  localparam int IDX_W        = $clog2(MAX_ELEMENTS);
  localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
  localparam int STK_W        = 2 * IDX_W;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_LOAD,
    WR_UP_DVAL,
    WR_DOWN_UVAL,
    WR_LO_DVAL,
    WR_DOWN_PIV
  } wr_sel_e;

  typedef enum logic [2:0] {
    RD_NONE,
    RD_LO,
    RD_UP,
    RD_DOWN,
    RD_K
  } rd_sel_e;

  typedef struct packed {
    wr_sel_e wr_sel;
    rd_sel_e rd_sel;
    logic    init_push;
    logic    pop;
    logic    latch_range;
    logic    latch_piv;
    logic    up_inc;
    logic    latch_uval;
    logic    down_dec;
    logic    latch_dval;
    logic    push_left;
    logic    push_right;
    logic    emit_load;
    logic    clear;
  } dp_cmd_t;

  typedef struct packed {
    logic sp_zero;
    logic range_bad;
    logic up_gt_hi;
    logic rd_le_piv;
    logic up_lt_down;
    logic k_done;
    logic out_busy;
  } dp_status_t;

endpackage

// ===== src/qse_ram.sv =====
module qse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/qse_datapath.sv =====
module qse_datapath
  import qse_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dp_cmd_t               cmd_i,
  output dp_status_t            status_o,
  input  logic [DATA_WIDTH-1:0] in_value_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [DATA_WIDTH-1:0] out_value_o,
  output logic                  out_last_o,
  output logic                  out_ovf_o
);

  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] sp_q, sp_d;
  logic [CNT_W-1:0] k_q, k_d;
  logic             ovf_q, ovf_d;
  logic             out_valid_q, out_valid_d;
  logic [IDX_W-1:0] lo_q, hi_q, down_q;
  logic [CNT_W-1:0] up_q;
  logic [DATA_WIDTH-1:0] piv_q, uval_q, dval_q;
  logic [DATA_WIDTH-1:0] out_value_q;
  logic             out_last_q, out_ovf_q;

  logic                  st_we, st_re;
  logic [IDX_W-1:0]      st_waddr, st_raddr;
  logic [DATA_WIDTH-1:0] st_wdata, st_rdata;
  logic                  sk_we;
  logic [IDX_W-1:0]      sk_waddr;
  logic [STK_W-1:0]      sk_wdata, sk_rdata;
  logic [CNT_W-1:0]      sp_m1;
  logic                  not_full, sk_room, left_ok, right_ok;

  assign sp_m1    = sp_q - 1'b1;
  assign not_full = count_q < CNT_W'(MAX_ELEMENTS);
  assign sk_room  = sp_q < CNT_W'(MAX_ELEMENTS);
  assign left_ok  = {1'b0, down_q} > ({1'b0, lo_q} + 1'b1);
  assign right_ok = ({1'b0, down_q} + 1'b1) < {1'b0, hi_q};

  qse_ram #(.WIDTH(DATA_WIDTH), .DEPTH(MAX_ELEMENTS)) u_store (
    .clk_i  (clk_i),
    .we_i   (st_we),
    .waddr_i(st_waddr),
    .wdata_i(st_wdata),
    .re_i   (st_re),
    .raddr_i(st_raddr),
    .rdata_o(st_rdata)
  );

  qse_ram #(.WIDTH(STK_W), .DEPTH(MAX_ELEMENTS)) u_stack (
    .clk_i  (clk_i),
    .we_i   (sk_we),
    .waddr_i(sk_waddr),
    .wdata_i(sk_wdata),
    .re_i   (cmd_i.pop),
    .raddr_i(sp_m1[IDX_W-1:0]),
    .rdata_o(sk_rdata)
  );

  always_comb begin
    st_we    = 1'b0;
    st_waddr = count_q[IDX_W-1:0];
    st_wdata = in_value_i;
    case (cmd_i.wr_sel)
      WR_LOAD: begin
        st_we = not_full;
      end
      WR_UP_DVAL: begin
        st_we    = 1'b1;
        st_waddr = up_q[IDX_W-1:0];
        st_wdata = dval_q;
      end
      WR_DOWN_UVAL: begin
        st_we    = 1'b1;
        st_waddr = down_q;
        st_wdata = uval_q;
      end
      WR_LO_DVAL: begin
        st_we    = 1'b1;
        st_waddr = lo_q;
        st_wdata = dval_q;
      end
      WR_DOWN_PIV: begin
        st_we    = 1'b1;
        st_waddr = down_q;
        st_wdata = piv_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    st_re    = 1'b1;
    st_raddr = lo_q;
    case (cmd_i.rd_sel)
      RD_LO:   st_raddr = lo_q;
      RD_UP:   st_raddr = up_q[IDX_W-1:0];
      RD_DOWN: st_raddr = down_q;
      RD_K:    st_raddr = k_q[IDX_W-1:0];
      default: st_re = 1'b0;
    endcase
  end

  always_comb begin
    sk_we    = 1'b0;
    sk_waddr = sp_q[IDX_W-1:0];
    sk_wdata = {lo_q, down_q - 1'b1};
    sp_d     = sp_q;
    if (cmd_i.init_push) begin
      sk_waddr = '0;
      sk_wdata = {{IDX_W{1'b0}}, sp_m1[IDX_W-1:0]};
      if (count_q >= CNT_W'(2)) begin
        sk_we    = 1'b1;
        sk_wdata = {{IDX_W{1'b0}}, IDX_W'(count_q - 1'b1)};
        sp_d     = CNT_W'(1);
      end
    end else if (cmd_i.pop) begin
      sp_d = sp_m1;
    end else if (cmd_i.push_left) begin
      if (left_ok && sk_room) begin
        sk_we = 1'b1;
        sp_d  = sp_q + 1'b1;
      end
    end else if (cmd_i.push_right) begin
      sk_wdata = {down_q + 1'b1, hi_q};
      if (right_ok && sk_room) begin
        sk_we = 1'b1;
        sp_d  = sp_q + 1'b1;
      end
    end
    if (cmd_i.clear) begin
      sp_d = '0;
    end
  end

  always_comb begin
    count_d     = count_q;
    ovf_d       = ovf_q;
    k_d         = k_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.wr_sel == WR_LOAD) begin
      if (not_full) begin
        count_d = count_q + 1'b1;
      end else begin
        ovf_d = 1'b1;
      end
    end
    if (cmd_i.emit_load) begin
      out_valid_d = 1'b1;
      k_d         = k_q + 1'b1;
    end
    if (cmd_i.clear) begin
      count_d = '0;
      ovf_d   = 1'b0;
      k_d     = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      sp_q        <= '0;
      k_q         <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      sp_q        <= sp_d;
      k_q         <= k_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_range) begin
      lo_q <= sk_rdata[STK_W-1:IDX_W];
      hi_q <= sk_rdata[IDX_W-1:0];
    end
    if (cmd_i.latch_piv) begin
      piv_q  <= st_rdata;
      up_q   <= {1'b0, lo_q} + 1'b1;
      down_q <= hi_q;
    end
    if (cmd_i.up_inc) begin
      up_q <= up_q + 1'b1;
    end
    if (cmd_i.latch_uval) begin
      uval_q <= st_rdata;
    end
    if (cmd_i.down_dec) begin
      down_q <= down_q - 1'b1;
    end
    if (cmd_i.latch_dval) begin
      dval_q <= st_rdata;
    end
    if (cmd_i.emit_load) begin
      out_value_q <= st_rdata;
      out_last_q  <= (k_q + 1'b1) == count_q;
      out_ovf_q   <= ovf_q;
    end
  end

  assign status_o.sp_zero    = sp_q == '0;
  assign status_o.range_bad  = (lo_q >= hi_q) || ({1'b0, hi_q} >= count_q);
  assign status_o.up_gt_hi   = up_q > {1'b0, hi_q};
  assign status_o.rd_le_piv  = $signed(st_rdata) <= $signed(piv_q);
  assign status_o.up_lt_down = up_q < {1'b0, down_q};
  assign status_o.k_done     = k_q == count_q;
  assign status_o.out_busy   = out_valid_q;

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign out_last_o  = out_last_q;
  assign out_ovf_o   = out_ovf_q;

  a_sp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= CNT_W'(MAX_ELEMENTS))
    else $error("range stack pointer beyond depth");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_ELEMENTS))
    else $error("element count beyond capacity");

  a_down_sentinel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.down_dec |-> down_q > lo_q)
    else $error("down scan passed the pivot");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_load |-> !out_valid_q)
    else $error("output register overwritten");

  a_emit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_load |-> k_q < count_q)
    else $error("emit beyond element count");

endmodule

// ===== src/qse_ctrl.sv =====
module qse_ctrl
  import qse_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_last_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  localparam logic [4:0] S_LOAD   = 5'd0;
  localparam logic [4:0] S_INIT   = 5'd1;
  localparam logic [4:0] S_POP    = 5'd2;
  localparam logic [4:0] S_POPW   = 5'd3;
  localparam logic [4:0] S_RANGE  = 5'd4;
  localparam logic [4:0] S_PIVW   = 5'd5;
  localparam logic [4:0] S_SCANU  = 5'd6;
  localparam logic [4:0] S_SCANUW = 5'd7;
  localparam logic [4:0] S_SCAND  = 5'd8;
  localparam logic [4:0] S_SCANDW = 5'd9;
  localparam logic [4:0] S_SWAP1  = 5'd10;
  localparam logic [4:0] S_SWAP2  = 5'd11;
  localparam logic [4:0] S_FIN1   = 5'd12;
  localparam logic [4:0] S_FIN2   = 5'd13;
  localparam logic [4:0] S_PUSHL  = 5'd14;
  localparam logic [4:0] S_PUSHR  = 5'd15;
  localparam logic [4:0] S_EMRD   = 5'd16;
  localparam logic [4:0] S_EMWT   = 5'd17;

  logic [4:0] state_q, state_d;

  assign in_ready_o = state_q == S_LOAD;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.wr_sel = WR_NONE;
    cmd_o.rd_sel = RD_NONE;
    case (state_q)
      S_LOAD: begin
        if (in_valid_i) begin
          cmd_o.wr_sel = WR_LOAD;
          if (in_last_i) begin
            state_d = S_INIT;
          end
        end
      end
      S_INIT: begin
        cmd_o.init_push = 1'b1;
        state_d = S_POP;
      end
      S_POP: begin
        if (status_i.sp_zero) begin
          state_d = S_EMRD;
        end else begin
          cmd_o.pop = 1'b1;
          state_d = S_POPW;
        end
      end
      S_POPW: begin
        cmd_o.latch_range = 1'b1;
        state_d = S_RANGE;
      end
      S_RANGE: begin
        if (status_i.range_bad) begin
          state_d = S_POP;
        end else begin
          cmd_o.rd_sel = RD_LO;
          state_d = S_PIVW;
        end
      end
      S_PIVW: begin
        cmd_o.latch_piv = 1'b1;
        state_d = S_SCANU;
      end
      S_SCANU: begin
        if (status_i.up_gt_hi) begin
          state_d = S_SCAND;
        end else begin
          cmd_o.rd_sel = RD_UP;
          state_d = S_SCANUW;
        end
      end
      S_SCANUW: begin
        if (status_i.rd_le_piv) begin
          cmd_o.up_inc = 1'b1;
          state_d = S_SCANU;
        end else begin
          cmd_o.latch_uval = 1'b1;
          state_d = S_SCAND;
        end
      end
      S_SCAND: begin
        cmd_o.rd_sel = RD_DOWN;
        state_d = S_SCANDW;
      end
      S_SCANDW: begin
        if (!status_i.rd_le_piv) begin
          cmd_o.down_dec = 1'b1;
          state_d = S_SCAND;
        end else begin
          cmd_o.latch_dval = 1'b1;
          state_d = status_i.up_lt_down ? S_SWAP1 : S_FIN1;
        end
      end
      S_SWAP1: begin
        cmd_o.wr_sel = WR_UP_DVAL;
        state_d = S_SWAP2;
      end
      S_SWAP2: begin
        cmd_o.wr_sel = WR_DOWN_UVAL;
        state_d = S_SCANU;
      end
      S_FIN1: begin
        cmd_o.wr_sel = WR_LO_DVAL;
        state_d = S_FIN2;
      end
      S_FIN2: begin
        cmd_o.wr_sel = WR_DOWN_PIV;
        state_d = S_PUSHL;
      end
      S_PUSHL: begin
        cmd_o.push_left = 1'b1;
        state_d = S_PUSHR;
      end
      S_PUSHR: begin
        cmd_o.push_right = 1'b1;
        state_d = S_POP;
      end
      S_EMRD: begin
        if (status_i.k_done) begin
          cmd_o.clear = 1'b1;
          state_d = S_LOAD;
        end else if (!status_i.out_busy) begin
          cmd_o.rd_sel = RD_K;
          state_d = S_EMWT;
        end
      end
      S_EMWT: begin
        cmd_o.emit_load = 1'b1;
        state_d = S_EMRD;
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  a_load_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.wr_sel == WR_LOAD) |-> state_q == S_LOAD)
    else $error("element stored outside loading");

  a_emit_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit_load |-> $past(cmd_o.rd_sel) == RD_K)
    else $error("emit without a store read");

  a_swap_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.wr_sel == WR_UP_DVAL) |=> (cmd_o.wr_sel == WR_DOWN_UVAL))
    else $error("swap left half done");

endmodule

// ===== src/quicksort_engine_core.sv =====
// Sorting engine for sets of up to 64 signed 32-bit values. Values arrive one
// transfer per cycle on the slave stream while the engine is loading; the
// transfer with tlast closes the set. Values past capacity are dropped and
// every result of that set carries the overflow flag in tuser. The set is then
// sorted in place by quicksort (first element of each range as pivot, pending
// ranges kept on a stack in RAM) and played out smallest first on the master
// stream, tlast on the largest. The sort time depends on the data: each scan
// step reads one element from the element RAM and compares it with the pivot.
// Results are then played out one at a time; the next is read from the store
// only once the sink has taken the previous one from the output register.
// No input is taken from the closing transfer until the last result has been
// loaded into the output register. No clearing pass follows reset.
module quicksort_engine_core
  import qse_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [DATA_WIDTH-1:0] s_axis_tdata_i,   // value
  input  logic                  s_axis_tlast_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [DATA_WIDTH-1:0] m_axis_tdata_o,   // sorted_value
  output logic                  m_axis_tlast_o,
  output logic                  m_axis_tuser_o    // overflowed
);

  dp_cmd_t    cmd;
  dp_status_t status;

  qse_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid_i),
    .in_last_i (s_axis_tlast_i),
    .in_ready_o(s_axis_tready_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  qse_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .in_value_i (s_axis_tdata_i),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .out_value_o(m_axis_tdata_o),
    .out_last_o (m_axis_tlast_o),
    .out_ovf_o  (m_axis_tuser_o)
  );

endmodule
